### rtl/utn_pkg.sv
`default_nettype none
package utn_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CP_W      = 21;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  typedef struct packed {
    logic add_leading_space;
    logic collapse_whitespace;
    logic escape_spaces;
  } cfg_t;

  // one input byte's worth of code points: code0 is the only wide one,
  // the others are single bytes taken alone
  typedef struct packed {
    logic [CP_W-1:0] code0;
    logic [2:0][7:0] cbyte;
    logic [3:0]      emit;
    logic [3:0]      swal;
    logic            last;
  } work_t;

endpackage
`default_nettype wire

### rtl/utn_front.sv
`default_nettype none
module utn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  utn_pkg::in_item_t item,
  input  utn_pkg::cfg_t     cfg,
  output logic              wr,
  output utn_pkg::work_t    work
);
  import utn_pkg::*;

  localparam logic [CP_W-1:0] CP_IDEO_SPACE = 21'h3000;
  localparam logic [CP_W-1:0] CP_FW_LO      = 21'hFF01;
  localparam logic [CP_W-1:0] CP_FW_HI      = 21'hFF5E;
  localparam logic [CP_W-1:0] CP_FW_OFS     = 21'hFEE0;
  localparam logic [CP_W-1:0] CP_SPACE      = 21'h20;

  function automatic logic is_ws(input logic [CP_W-1:0] c);
    return (c == CP_SPACE) || (c >= 21'h09 && c <= 21'h0D) || (c == 21'h85) ||
           (c == 21'hA0) || (c == 21'h1680) || (c >= 21'h2000 && c <= 21'h200A) ||
           (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202F) ||
           (c == 21'h205F) || (c == CP_IDEO_SPACE);
  endfunction

  logic [7:0]      lead_r, lead_nxt;
  logic [2:0]      seq_len_r, seq_len_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [1:0][7:0] cont_r, cont_nxt;

  logic [7:0]      b;
  logic            last, pending, is_cont, store, done_seq, pre_inc, b_inc;
  logic [2:0]      blen, pcnt, count;
  logic [3:0][7:0] items;
  logic [CP_W-1:0] v, raw0, mapped;
  logic [3:0]      ws;

  always_comb begin
    b       = item.in_byte;
    last    = item.text_last;
    pending = seq_len_r != 3'd0;
    is_cont = b[7:6] == 2'b10;
    if (b[7:5] == 3'b110) begin
      blen = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      blen = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      blen = 3'd4;
    end else begin
      blen = 3'd1;
    end
    store    = pending && is_cont && (({1'b0, cnt_r} + 3'd1) < (seq_len_r - 3'd1));
    done_seq = pending && is_cont && !store;
    pre_inc  = (pending && !is_cont) || (store && last);
    if (done_seq) begin
      b_inc = 1'b0;
    end else if (store) begin
      b_inc = last;
    end else begin
      b_inc = (blen == 3'd1) || last;
    end
    pcnt  = pre_inc ? ({1'b0, cnt_r} + 3'd1) : 3'd0;
    count = done_seq ? 3'd1 : (pcnt + {2'b00, b_inc});

    items[0] = (pcnt > 3'd0) ? lead_r : b;
    items[1] = (pcnt > 3'd1) ? cont_r[0] : b;
    items[2] = (pcnt > 3'd2) ? cont_r[1] : b;
    items[3] = b;

    case (seq_len_r)
      3'd2:    v = {10'd0, lead_r[4:0], b[5:0]};
      3'd3:    v = {5'd0, lead_r[3:0], cont_r[0][5:0], b[5:0]};
      default: v = {lead_r[2:0], cont_r[0][5:0], cont_r[1][5:0], b[5:0]};
    endcase

    raw0 = done_seq ? v : {13'd0, items[0]};
    if (raw0 == CP_IDEO_SPACE) begin
      mapped = CP_SPACE;
    end else if (raw0 >= CP_FW_LO && raw0 <= CP_FW_HI) begin
      mapped = raw0 - CP_FW_OFS;
    end else begin
      mapped = raw0;
    end

    ws[0] = is_ws(mapped);
    for (int i = 1; i < 4; i++) begin
      ws[i] = is_ws({13'd0, items[i]});
    end

    work.code0 = mapped;
    for (int i = 0; i < 3; i++) begin
      work.cbyte[i] = items[i+1];
    end
    for (int i = 0; i < 4; i++) begin
      work.emit[i] = (3'(i) < count) && !(ws[i] && cfg.collapse_whitespace);
      work.swal[i] = (3'(i) < count) && ws[i] && cfg.collapse_whitespace;
    end
    work.last = last;
    wr        = acc && ((count != 3'd0) || last);
  end

  always_comb begin
    lead_nxt    = lead_r;
    seq_len_nxt = seq_len_r;
    cnt_nxt     = cnt_r;
    cont_nxt    = cont_r;
    if (acc) begin
      if (last) begin
        seq_len_nxt = 3'd0;
        cnt_nxt     = 2'd0;
      end else if (store) begin
        cont_nxt[cnt_r[0]] = b;
        cnt_nxt            = cnt_r + 2'd1;
      end else if (done_seq || blen == 3'd1) begin
        seq_len_nxt = 3'd0;
        cnt_nxt     = 2'd0;
      end else begin
        lead_nxt    = b;
        seq_len_nxt = blen;
        cnt_nxt     = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= 3'd0;
      cnt_r     <= 2'd0;
    end else begin
      seq_len_r <= seq_len_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_r <= lead_nxt;
    cont_r <= cont_nxt;
  end

endmodule
`default_nettype wire

### rtl/utn_fifo.sv
`default_nettype none
module utn_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  utn_pkg::work_t wdata,
  input  logic           rd,
  output utn_pkg::work_t rdata,
  output logic           full,
  output logic           valid
);
  import utn_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  work_t         mem_r [DEPTH];
  work_t         rdata_r;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(wr) - CW'(rd);
    full    = cnt_r == CW'(DEPTH);
    valid   = cnt_r != '0;
    rdata   = rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold the head entry; take the incoming transfer when it lands there
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
    if (wr && wp_r == rp_nxt) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem_r[rp_nxt];
    end
  end

endmodule
`default_nettype wire

### rtl/utn_back.sv
`default_nettype none
module utn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  utn_pkg::cfg_t      cfg,
  input  logic               valid,
  input  utn_pkg::work_t     work,
  output logic               rd,
  input  logic               pop,
  output logic               empty,
  output utn_pkg::out_item_t out_item
);
  import utn_pkg::*;

  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] ESC0  = 8'hE2;
  localparam logic [7:0] ESC1  = 8'h96;
  localparam logic [7:0] ESC2  = 8'h81;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  function automatic enc_t encode(input logic [CP_W-1:0] c);
    enc_t e;
    e.b = '0;
    if (c <= 21'h7F) begin
      e.b[0] = c[7:0];
      e.n    = 3'd1;
    end else if (c <= 21'h7FF) begin
      e.b[0] = {3'b110, c[10:6]};
      e.b[1] = {2'b10, c[5:0]};
      e.n    = 3'd2;
    end else if (c <= 21'hFFFF) begin
      e.b[0] = {4'b1110, c[15:12]};
      e.b[1] = {2'b10, c[11:6]};
      e.b[2] = {2'b10, c[5:0]};
      e.n    = 3'd3;
    end else begin
      e.b[0] = {5'b11110, c[20:18]};
      e.b[1] = {2'b10, c[17:12]};
      e.b[2] = {2'b10, c[11:6]};
      e.b[3] = {2'b10, c[5:0]};
      e.n    = 3'd4;
    end
    return e;
  endfunction

  logic [2:0] pos_r, pos_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic       held_r, held_nxt;
  logic       started_r, started_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  logic [3:0]      ge, lt_k, gt_k, emit_rem;
  logic [1:0]      k;
  logic            has_emit, skip_ws, more_emit, tail_swal, rem_swal;
  logic [CP_W-1:0] cp;
  enc_t            enc;
  logic            held_eff, pre, esc, lb_done, code_done, fin, out_free, fire;
  logic [2:0]      eff_slot;
  logic [7:0]      lb, raw;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ge[i] = 3'(i) >= pos_r;
    end
    emit_rem = work.emit & ge;
    has_emit = |emit_rem;
    if (emit_rem[0]) begin
      k = 2'd0;
    end else if (emit_rem[1]) begin
      k = 2'd1;
    end else if (emit_rem[2]) begin
      k = 2'd2;
    end else begin
      k = 2'd3;
    end
    for (int i = 0; i < 4; i++) begin
      lt_k[i] = 2'(i) < k;
      gt_k[i] = 2'(i) > k;
    end
    skip_ws   = |(work.swal & ge & lt_k);
    more_emit = |(work.emit & gt_k);
    tail_swal = |(work.swal & gt_k);
    rem_swal  = |(work.swal & ge);

    cp  = (k == 2'd0) ? work.code0 : {13'd0, work.cbyte[k - 2'd1]};
    enc = encode(cp);

    held_eff = held_r || (skip_ws && started_r);
    pre      = held_eff || (!started_r && cfg.add_leading_space && enc.b[0] != SPACE);
    eff_slot = (slot_r == 3'd0 && !pre) ? 3'd1 : slot_r;
    lb       = (eff_slot == 3'd0) ? SPACE : enc.b[2'(eff_slot - 3'd1)];
    esc      = cfg.escape_spaces && lb == SPACE;
    case (sub_r)
      2'd0:    raw = esc ? ESC0 : lb;
      2'd1:    raw = ESC1;
      default: raw = ESC2;
    endcase
    lb_done   = !esc || sub_r == 2'd2;
    code_done = lb_done && eff_slot == enc.n;
    fin       = code_done && !more_emit;

    out_free = !out_valid_r || pop;
    fire     = valid && ((!has_emit && !work.last) || out_free);
    rd       = fire && (!has_emit || fin);
  end

  always_comb begin
    pos_nxt       = pos_r;
    slot_nxt      = slot_r;
    sub_nxt       = sub_r;
    held_nxt      = held_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (pop) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      if (has_emit) begin
        out_valid_nxt        = 1'b1;
        out_nxt.out_byte     = raw;
        out_nxt.byte_present = 1'b1;
        out_nxt.run_last     = fin;
        out_nxt.text_end     = fin && work.last;
        if (!lb_done) begin
          sub_nxt  = sub_r + 2'd1;
          slot_nxt = eff_slot;
        end else if (!code_done) begin
          sub_nxt  = 2'd0;
          slot_nxt = eff_slot + 3'd1;
        end else begin
          sub_nxt     = 2'd0;
          slot_nxt    = 3'd0;
          pos_nxt     = {1'b0, k} + 3'd1;
          held_nxt    = 1'b0;
          started_nxt = 1'b1;
          if (!more_emit) begin
            pos_nxt  = 3'd0;
            held_nxt = tail_swal;
            if (work.last) begin
              held_nxt    = 1'b0;
              started_nxt = 1'b0;
            end
          end
        end
      end else begin
        pos_nxt  = 3'd0;
        held_nxt = held_r || (started_r && rem_swal);
        if (work.last) begin
          held_nxt             = 1'b0;
          started_nxt          = 1'b0;
          out_valid_nxt        = 1'b1;
          out_nxt.out_byte     = 8'h00;
          out_nxt.byte_present = 1'b0;
          out_nxt.run_last     = 1'b1;
          out_nxt.text_end     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 3'd0;
      slot_r      <= 3'd0;
      sub_r       <= 2'd0;
      held_r      <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      slot_r      <= slot_nxt;
      sub_r       <= sub_nxt;
      held_r      <= held_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

endmodule
`default_nettype wire

### rtl/utf8_text_normalizer_unit.sv
// Channel   Handshake           Payload
// input     push / full         in_item  (in_byte, text_last)
// result    pop / empty         out_item (out_byte, byte_present, run_last, text_end)
// config    cfg_we, cfg_idx     cfg_data (bit 0)
//
// Input bytes are taken one per cycle while the work queue has room.
// The back end writes one result byte per cycle while its result register is free or popped;
// an item yields 1 to 12 result bytes there, or none.
// Sustained rate is set by the single result byte port behind the back end.
// Reset is synchronous, active low: queue emptied, config bits back to 1.
// A stalled result side fills the queue and then raises full.
`default_nettype none
module utf8_text_normalizer_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  utn_pkg::in_item_t               in_item,
  input  logic                            pop,
  output logic                            empty,
  output utn_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [utn_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic                            cfg_data
);
  import utn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_ADD_LEADING_SPACE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE_WHITESPACE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_SPACES       = 2'd2;

  cfg_t  cfg_r, cfg_nxt;
  logic  acc, wr, rd, q_valid;
  work_t wdata, rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_ADD_LEADING_SPACE:   cfg_nxt.add_leading_space   = cfg_data;
        CFG_COLLAPSE_WHITESPACE: cfg_nxt.collapse_whitespace = cfg_data;
        CFG_ESCAPE_SPACES:       cfg_nxt.escape_spaces       = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign acc = push && !full;

  utn_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_item),
    .cfg   (cfg_r),
    .wr    (wr),
    .work  (wdata)
  );

  utn_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .wdata (wdata),
    .rd    (rd),
    .rdata (rdata),
    .full  (full),
    .valid (q_valid)
  );

  utn_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .valid    (q_valid),
    .work     (rdata),
    .rd       (rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

### rtl/utn_checker.sv
`default_nettype none
module utn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               pop,
  input logic               empty,
  input utn_pkg::out_item_t out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.byte_present) |->
      (out_item.run_last && out_item.text_end && out_item.out_byte == 8'h00))
    else $error("bare end marker malformed");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.text_end) |-> out_item.run_last)
    else $error("text end without run end");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or dropped");

endmodule

bind utf8_text_normalizer_unit utn_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .pop      (pop),
  .empty    (empty),
  .out_item (out_item)
);
`default_nettype wire
